[sv/lhe_pkg.sv]
// Shared types, codes and constants of the luma histogram engine.
package lhe_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int NUM_BINS    = 256;
    localparam int BIN_BITS    = $clog2(NUM_BINS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_BITS    = 24;

    // BT.601 weights in 16-bit fixed point; they sum to 2^16
    localparam logic [SUM_BITS-1:0] W_RED   = SUM_BITS'(19595);
    localparam logic [SUM_BITS-1:0] W_GREEN = SUM_BITS'(38470);
    localparam logic [SUM_BITS-1:0] W_BLUE  = SUM_BITS'(7471);

    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_CLR  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] bin_select;
    } lhe_in_t;

    typedef struct packed {
        logic [7:0]  luma;
        logic [31:0] bin_count;
    } lhe_out_t;

    typedef enum logic [1:0] {
        OP_ACC,
        OP_CLR,
        OP_READ,
        OP_NOP
    } lhe_op_t;

    // one classified item: bin is the luma on accumulate, the selected bin on read
    typedef struct packed {
        lhe_op_t             op;
        logic [BIN_BITS-1:0] bin;
    } lhe_entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_WAIT
    } lhe_bk_state_t;

endpackage

[sv/lhe_front.sv]
// Front end: holds the enable register, computes luma and classifies each item.
module lhe_front
    import lhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       enable_we,
    input  logic       enable_wdata,
    input  logic       in_valid,
    input  lhe_in_t    in_item,
    input  logic       q_full,
    output logic       in_stall,
    output logic       q_push,
    output lhe_entry_t q_entry
);

    logic                enable_reg;
    logic                enable_next;
    logic [SUM_BITS-1:0] luma_sum;

    always_comb
    begin
        enable_next = enable_we ? enable_wdata : enable_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else
        begin
            enable_reg <= enable_next;
        end
    end

    // constant weights: shift-and-add products, sum stays below 2^24
    assign luma_sum = W_RED * SUM_BITS'(in_item.red)
                    + W_GREEN * SUM_BITS'(in_item.green)
                    + W_BLUE * SUM_BITS'(in_item.blue);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.op  = OP_NOP;
        q_entry.bin = '0;
        if (enable_reg)
        begin
            unique case (in_item.mode)
                MODE_ACC:
                begin
                    q_entry.op  = OP_ACC;
                    q_entry.bin = luma_sum[SUM_BITS-1 -: BIN_BITS];
                end
                MODE_CLR:
                begin
                    q_entry.op = OP_CLR;
                end
                MODE_READ:
                begin
                    q_entry.op  = OP_READ;
                    q_entry.bin = in_item.bin_select;
                end
                default:
                begin
                    // unused mode: pass through as a no-op
                    q_entry.op = OP_NOP;
                end
            endcase
        end
    end

endmodule

[sv/lhe_queue.sv]
// Short FIFO of classified items between the front and back ends.
module lhe_queue
    import lhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lhe_entry_t push_entry,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output lhe_entry_t head
);

    lhe_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[sv/lhe_back.sv]
// Back end: bin memory with valid bits, read-modify-write sequencer, result register.
module lhe_back
    import lhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  lhe_entry_t q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output lhe_out_t   out_item
);

    count_t              mem [NUM_BINS];
    count_t              rd_data_reg;
    logic                rd_vld_reg;
    logic [NUM_BINS-1:0] bin_valid_reg;
    logic [NUM_BINS-1:0] bin_valid_next;

    lhe_bk_state_t       state_reg;
    lhe_bk_state_t       state_next;
    lhe_entry_t          cur_reg;
    lhe_entry_t          cur_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    lhe_out_t            out_item_reg;
    lhe_out_t            out_item_next;

    logic                out_load;
    logic                out_free;
    logic                clr_all;
    logic                mem_we;
    count_t              rd_cnt;
    count_t              inc_cnt;

    assign out_free = !out_valid_reg || !out_stall;
    assign rd_cnt   = rd_vld_reg ? rd_data_reg : '0;
    // saturate at the counter maximum
    assign inc_cnt  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        q_pop         = 1'b0;
        out_load      = 1'b0;
        out_item_next = out_item_reg;
        clr_all       = 1'b0;
        mem_we        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty && out_free)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    unique case (q_head.op)
                        OP_ACC, OP_READ:
                        begin
                            state_next = BK_WAIT;
                        end
                        OP_CLR:
                        begin
                            clr_all       = 1'b1;
                            out_load      = 1'b1;
                            out_item_next = '0;
                        end
                        OP_NOP:
                        begin
                            out_load      = 1'b1;
                            out_item_next = '0;
                        end
                    endcase
                end
            end
            BK_WAIT:
            begin
                out_load   = 1'b1;
                state_next = BK_IDLE;
                if (cur_reg.op == OP_ACC)
                begin
                    mem_we                  = 1'b1;
                    out_item_next.luma      = cur_reg.bin;
                    out_item_next.bin_count = '0;
                end
                else
                begin
                    out_item_next.luma      = '0;
                    out_item_next.bin_count = 32'(rd_cnt);
                end
            end
        endcase
    end

    always_comb
    begin
        bin_valid_next = bin_valid_reg;
        if (clr_all)
        begin
            bin_valid_next = '0;
        end
        else if (mem_we)
        begin
            bin_valid_next[cur_reg.bin] = 1'b1;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            bin_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bin_valid_reg <= bin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg.bin] <= inc_cnt;
        end
        rd_data_reg <= mem[q_head.bin];
        rd_vld_reg  <= bin_valid_reg[q_head.bin];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[sv/luma_histogram_engine_top.sv]
// Top level of the luma histogram engine: front end, item queue and back end.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries one item per handshake:
//   accumulate a pixel (mode 0), clear all 256 bins (mode 1) or read one bin
//   (mode 2). Output channel out_valid / out_stall / out_item returns exactly
//   one result item per input item, in order: the pixel's luma on accumulate,
//   the bin count on read, zeros otherwise and whenever enable is 0.
//   enable_we / enable_wdata write the enable register; write it only while
//   no item is in flight.
// Flow:
//   An accepted input item enters the queue and is popped by the back end in
//   its idle state. Accumulate and read then pass the wait state (registered
//   memory read, then write back on accumulate or the count on read) before
//   the result register is loaded; clear and ignored items load it straight
//   from the idle state. The back end takes no new item while in the wait
//   state or while a stalled result holds the result register. A 2-entry queue
//   lets the input keep taking items while the back end works or a result waits.
// Reset:
//   rst_n clears enable, the queue, the result valid flag and all bin valid
//   bits at once, so every bin reads zero right after reset. A clear item
//   likewise zeroes all bins at once.
// Stall:
//   While out_stall is high the result holds; the back end stops once the
//   result register is full, then the queue fills and in_stall rises.
module luma_histogram_engine_top
    import lhe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     enable_we,
    input  logic     enable_wdata,
    input  logic     in_valid,
    output logic     in_stall,
    input  lhe_in_t  in_item,
    output logic     out_valid,
    input  logic     out_stall,
    output lhe_out_t out_item
);

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    lhe_entry_t q_push_entry;
    lhe_entry_t q_head;

    // classify items and compute luma as they arrive
    lhe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable_we    (enable_we),
        .enable_wdata (enable_wdata),
        .in_valid     (in_valid),
        .in_item      (in_item),
        .q_full       (q_full),
        .in_stall     (in_stall),
        .q_push       (q_push),
        .q_entry      (q_push_entry)
    );

    // decouple intake from the memory sequencer
    lhe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // update or read the bins and deliver results
    lhe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

[sv/lhe_checker.sv]
// Port-level checks for the luma histogram engine, bound to its top level.
module lhe_checker
    import lhe_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input lhe_in_t  in_item,
    input logic     out_valid,
    input logic     out_stall,
    input lhe_out_t out_item
);

    // a stalled input item stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
        else $error("stalled input item changed");

    // a result waiting on the receiver stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("stalled result changed");

    // a result never carries both a luma and a count
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.luma == 8'd0 || out_item.bin_count == 32'd0))
        else $error("luma and bin_count both set");

    // nothing is offered in the first cycle out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind luma_histogram_engine_top lhe_checker u_lhe_checker (.*);

[bench/luma_histogram_engine_top_tb.sv]
// Self-checking testbench of the luma histogram engine: directed table, then random traffic.
module luma_histogram_engine_top_tb;
    import lhe_pkg::*;

    // The package names the three live modes; the fourth code does nothing.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // BT.601 weights, 0.299 / 0.587 / 0.114 scaled by 2^16
    localparam int unsigned LUMA_WR = 19595;
    localparam int unsigned LUMA_WG = 38470;
    localparam int unsigned LUMA_WB = 7471;

    localparam int HOLD_CYCLES  = 64;          // long receiver hold-off
    localparam int HOLD_AFTER   = 700;         // items taken before that hold-off
    localparam int SETTLE       = 8;           // settling cycles after the last owed result
    localparam int WATCHDOG     = 2_000_000;   // time units, well past the slowest run

    // One line of the directed table: enable setting, item, and a result
    // typed in by hand where it is obvious (typed = 0 means ask the predictor).
    typedef struct {
        logic     en;
        lhe_in_t  item;
        logic     typed;
        lhe_out_t want;
    } plan_row_t;

    logic     clk;
    logic     rst_n        = 1'b0;
    logic     enable_we    = 1'b0;
    logic     enable_wdata = 1'b0;
    logic     in_valid     = 1'b0;
    logic     in_stall;
    lhe_in_t  in_item      = '0;
    logic     out_valid;
    logic     out_stall    = 1'b0;
    lhe_out_t out_item;

    // Predictor state: its own copy of the bins and of the enable register.
    count_t   hist_bins [NUM_BINS];
    logic     hist_enable = 1'b0;
    logic [7:0] last_luma = 8'd0;

    lhe_out_t due_readouts [$];   // results still owed by the block, oldest first
    int       items_taken   = 0;
    int       readouts_seen = 0;
    int       errors        = 0;

    luma_histogram_engine_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable_we    (enable_we),
        .enable_wdata (enable_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a result.
    initial
    begin : watchdog
        #WATCHDOG;
        $display("FAIL");
        $finish;
    end

    // Advance the histogram by one item and return the result it owes.
    // Luma is the truncated fixed-point weighted sum, capped at 255; a bin
    // at the counter maximum stays put. Disabled or spare-mode items leave
    // the bins alone and owe an all-zero result.
    function automatic lhe_out_t apply_pixel_item(lhe_in_t it);
        lhe_out_t    res;
        int unsigned weighted;
        logic [7:0]  y;
        res = '0;
        if (hist_enable)
        begin
            case (it.mode)
                MODE_ACC:
                begin
                    weighted = LUMA_WR * it.red + LUMA_WG * it.green + LUMA_WB * it.blue;
                    y = ((weighted >> 16) > 255) ? 8'd255 : 8'(weighted >> 16);
                    if (hist_bins[y] != '1)
                        hist_bins[y] = hist_bins[y] + 1'b1;
                    res.luma  = y;
                    last_luma = y;
                end
                MODE_CLR:
                begin
                    foreach (hist_bins[i])
                        hist_bins[i] = '0;
                end
                MODE_READ:
                    res.bin_count = 32'(hist_bins[it.bin_select]);
                default:
                    res = '0;
            endcase
        end
        return res;
    endfunction

    // Draw one random item. Accumulates dominate; gray and saturated pixels
    // pile counts into a few bins, and half the reads target the bin that
    // was just hit so that nonzero counts come back often. Unused fields
    // stay random so every bit toggles.
    function automatic lhe_in_t random_item();
        lhe_in_t it;
        int      kind;
        int      style;
        logic [7:0] gray;
        it.mode       = 2'($urandom_range(0, 3));
        it.red        = 8'($urandom);
        it.green      = 8'($urandom);
        it.blue       = 8'($urandom);
        it.bin_select = 8'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 68)
        begin
            it.mode = MODE_ACC;
            style   = $urandom_range(0, 19);
            if (style < 5)
            begin
                gray     = 8'($urandom_range(0, 7) * 36);
                it.red   = gray;
                it.green = gray;
                it.blue  = gray;
            end
            else if (style < 8)
            begin
                it.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                it.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
                it.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
        end
        else if (kind < 94)
        begin
            it.mode = MODE_READ;
            if ($urandom_range(0, 1))
                it.bin_select = last_luma;
        end
        else if (kind < 98)
            it.mode = MODE_SPARE;
        else
            it.mode = MODE_CLR;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until it is taken.
    // Valid stays high across back-to-back items; it drops only for a gap.
    // One 64-item stretch out of every three runs with no gaps at all.
    task automatic offer(input lhe_in_t it, input logic typed, input lhe_out_t want);
        int       gap;
        lhe_out_t predicted;
        gap = ((items_taken / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_pixel_item(it);
        due_readouts.push_back(typed ? want : predicted);
        items_taken++;
        @(negedge clk);
    endtask

    // Drain everything in flight, let the pipeline settle, then write enable.
    task automatic write_enable(input logic value);
        in_valid <= 1'b0;
        while (due_readouts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        enable_we    <= 1'b1;
        enable_wdata <= value;
        @(negedge clk);
        enable_we    <= 1'b0;
        hist_enable   = value;
    endtask

    // Compare one result, field by field, with the oldest one owed.
    task automatic check_readout(input lhe_out_t got);
        lhe_out_t exp_r;
        if (due_readouts.size() == 0)
        begin
            $display("%0t: unexpected result luma %0d count %0d",
                     $time, got.luma, got.bin_count);
            errors++;
        end
        else
        begin
            exp_r = due_readouts.pop_front();
            if (got.luma !== exp_r.luma)
            begin
                $display("%0t: luma mismatch: expected %0d, actual %0d",
                         $time, exp_r.luma, got.luma);
                errors++;
            end
            if (got.bin_count !== exp_r.bin_count)
            begin
                $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                         $time, exp_r.bin_count, got.bin_count);
                errors++;
            end
        end
    endtask

    // Result side: stall for a drawn number of cycles before each item,
    // change stall on the falling edge, take the item on the rising edge.
    // Once, after enough traffic, hold off long enough that the queue fills
    // and the block pushes back on its input.
    initial
    begin : result_side
        int  stall_left;
        logic long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
            begin
                check_readout(out_item);
                readouts_seen++;
                if (!long_hold_done && items_taken >= HOLD_AFTER)
                begin
                    stall_left     = HOLD_CYCLES;
                    long_hold_done = 1'b1;
                end
                else
                    stall_left = ((readouts_seen / 64) % 3 == 1) ? 0 : $urandom_range(0, 5);
            end
        end
    end

    // Build one row of the directed table.
    function automatic plan_row_t plan_row(input logic en, input logic [1:0] mode,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [7:0] sel,
                                           input logic typed, input logic [7:0] y,
                                           input logic [31:0] cnt);
        plan_row_t row;
        row.en              = en;
        row.item.mode       = mode;
        row.item.red        = r;
        row.item.green      = g;
        row.item.blue       = b;
        row.item.bin_select = sel;
        row.typed           = typed;
        row.want.luma       = y;
        row.want.bin_count  = cnt;
        return row;
    endfunction

    initial
    begin : stimulus
        plan_row_t plan [$];
        logic      phase_en  [5];
        int        phase_len [5];

        foreach (hist_bins[i])
            hist_bins[i] = '0;

        // Disabled after reset: nothing moves, every result is zero.
        plan.push_back(plan_row(1'b0, MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b0, MODE_ACC,   8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b0, MODE_CLR,   8'hff, 8'h00, 8'hff, 8'h00, 1'b1, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b0, MODE_SPARE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b0, MODE_READ,  8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd0, 32'd0));
        // Enabled: bins start empty after reset.
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 8'd0, 32'd0));
        // Black, white and each pure primary.
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0,   32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd255, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 8'd76,  32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'h00, 8'hff, 8'h00, 8'h00, 1'b1, 8'd149, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'h00, 8'h00, 8'hff, 8'h00, 1'b1, 8'd29,  32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd255, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 8'd0,   32'd2));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 8'd0,   32'd1));
        // Spare mode with every field set does nothing.
        plan.push_back(plan_row(1'b1, MODE_SPARE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 8'd0, 32'd0));
        // Alternating bit patterns, left to the predictor.
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'haa, 8'h55, 8'hf0, 8'h0f, 1'b0, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'h55, 8'haa, 8'h0f, 8'hf0, 1'b0, 8'd0, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'd76, 1'b1, 8'd0, 32'd1));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'haa, 1'b0, 8'd0, 32'd0));
        // Clear wipes every bin at once.
        plan.push_back(plan_row(1'b1, MODE_CLR,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0,   32'd0));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 8'd0,   32'd0));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'd149, 1'b1, 8'd0,  32'd0));
        plan.push_back(plan_row(1'b1, MODE_ACC,   8'hff, 8'hff, 8'hff, 8'h00, 1'b1, 8'd255, 32'd0));
        plan.push_back(plan_row(1'b1, MODE_READ,  8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 8'd0,   32'd1));

        // Random phases: mostly enabled, with two disabled stretches between.
        phase_en  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_len = '{400, 60, 400, 60, 405};

        // Hold reset low, then release it on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; change enable only when drained.
        foreach (plan[i])
        begin
            if (plan[i].en != hist_enable)
                write_enable(plan[i].en);
            offer(plan[i].item, plan[i].typed, plan[i].want);
        end

        // Each phase change drains the block, so the sender also pauses here
        // until every owed result has arrived.
        foreach (phase_en[p])
        begin
            write_enable(phase_en[p]);
            repeat (phase_len[p])
                offer(random_item(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (due_readouts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
